>>> hdl/pagu_pkg.sv
// Package for the packed ADC group unpacker: result codes, field widths
// and the result record that passes between the unpack logic and the output stage.
// No dependencies.
package pagu_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned INDEX_W   = 11;
    localparam int unsigned EXTRA_W   = 30;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned NSAMPLES  = 8;
    localparam int unsigned NPARTIAL  = 6;
    localparam int unsigned DCOUNT_W  = 12;
    localparam int unsigned TCOUNT_W  = 9;
    localparam int unsigned CELL_W    = 10;
    localparam int unsigned TDATA_W   = 144;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_ROW    = 2'd1,
        KIND_TRIG   = 2'd2,
        KIND_TAG    = 2'd3
    } kind_t;

    typedef logic [NSAMPLES-1:0][SAMPLE_W-1:0] samples_t;

    // Fields below kind follow the packing of m_tdata from the top bit down
    typedef struct packed {
        kind_t                kind;
        logic [EXTRA_W-1:0]   extra;
        samples_t             samples;
        logic [INDEX_W-1:0]   sample_index;
    } result_t;

endpackage

>>> hdl/pagu_in_stage.sv
// Input register of the packed ADC group unpacker: holds one word and its
// header flag until the unpack logic takes it. Depends on pagu_pkg.
module pagu_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pagu_pkg::WORD_W-1:0] s_word,
    input  logic                        s_first,
    input  logic                        take,
    output logic                        in_valid,
    output logic [pagu_pkg::WORD_W-1:0] in_word,
    output logic                        in_first
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [pagu_pkg::WORD_W-1:0] word_reg;
    logic                        first_reg;

    // Free when empty, or when the held word leaves in this cycle
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg  <= s_word;
            first_reg <= s_first;
        end
    end

    assign in_valid = valid_reg;
    assign in_word  = word_reg;
    assign in_first = first_reg;

endmodule

>>> hdl/pagu_unpack.sv
// Unpack logic of the packed ADC group unpacker: record region tracking,
// word counters and the 3-word-to-8-sample slicing. Depends on pagu_pkg.
module pagu_unpack (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [pagu_pkg::WORD_W-1:0] in_word,
    input  logic                        in_first,
    input  logic                        out_ready,
    output logic                        take,
    output logic                        res_valid,
    output pagu_pkg::result_t           res
);

    typedef enum logic [1:0] {
        REGION_IDLE = 2'd0,
        REGION_DATA = 2'd1,
        REGION_TRIG = 2'd2,
        REGION_TAG  = 2'd3
    } region_t;

    localparam logic [1:0] PHASE_W0 = 2'd0;
    localparam logic [1:0] PHASE_W1 = 2'd1;
    localparam logic [1:0] PHASE_W2 = 2'd2;

    region_t                                  region_reg, region_next;
    logic [pagu_pkg::DCOUNT_W-1:0]            data_words_reg, data_words_next;
    logic [pagu_pkg::TCOUNT_W-1:0]            trig_words_reg, trig_words_next;
    logic [pagu_pkg::DCOUNT_W-1:0]            words_seen_reg, words_seen_next;
    logic [1:0]                               phase_reg, phase_next;
    logic [pagu_pkg::INDEX_W-1:0]             row_reg, row_next;
    logic [pagu_pkg::NPARTIAL-1:0][pagu_pkg::SAMPLE_W-1:0] part_reg, part_next;

    logic [pagu_pkg::NPARTIAL-1:0][pagu_pkg::SAMPLE_W-1:0] part_take;
    logic [1:0]                               phase_take;
    logic                                     row_done;
    pagu_pkg::samples_t                       row_samples;
    logic [pagu_pkg::DCOUNT_W-1:0]            seen_inc;
    logic [pagu_pkg::DCOUNT_W-1:0]            hdr_dwords;
    logic [pagu_pkg::TCOUNT_W-1:0]            hdr_twords;

    assign take = in_valid && out_ready;

    // Slice one packed word according to its place in the triplet
    always_comb begin
        part_take   = part_reg;
        phase_take  = PHASE_W0;
        row_done    = 1'b0;
        row_samples = '0;
        case (phase_reg)
            PHASE_W0: begin
                part_take[0] = in_word[11:0];
                part_take[1] = in_word[23:12];
                part_take[2] = {4'd0, in_word[31:24]};
                phase_take   = PHASE_W1;
            end
            PHASE_W1: begin
                part_take[2] = part_reg[2] | {in_word[3:0], 8'd0};
                part_take[3] = in_word[15:4];
                part_take[4] = in_word[27:16];
                part_take[5] = {8'd0, in_word[31:28]};
                phase_take   = PHASE_W2;
            end
            default: begin
                row_samples[0] = part_reg[0];
                row_samples[1] = part_reg[1];
                row_samples[2] = part_reg[2];
                row_samples[3] = part_reg[3];
                row_samples[4] = part_reg[4];
                row_samples[5] = part_reg[5] | {in_word[7:0], 4'd0};
                row_samples[6] = in_word[19:8];
                row_samples[7] = in_word[31:20];
                phase_take     = PHASE_W0;
                row_done       = 1'b1;
            end
        endcase
    end

    assign seen_inc   = words_seen_reg + 1'b1;
    assign hdr_dwords = in_word[11:0];
    assign hdr_twords = in_word[12] ? in_word[11:3] : '0;

    always_comb begin
        region_next     = region_reg;
        data_words_next = data_words_reg;
        trig_words_next = trig_words_reg;
        words_seen_next = words_seen_reg;
        phase_next      = phase_reg;
        row_next        = row_reg;
        part_next       = part_reg;
        res_valid       = 1'b0;
        res             = '0;
        if (take) begin
            if (in_first) begin
                // Header: restart the record wherever we were
                res_valid       = 1'b1;
                res.kind        = pagu_pkg::KIND_HEADER;
                res.extra       = {20'd0, in_word[29:20]};
                data_words_next = hdr_dwords;
                trig_words_next = hdr_twords;
                words_seen_next = '0;
                phase_next      = PHASE_W0;
                row_next        = '0;
                if (hdr_dwords != '0) begin
                    region_next = REGION_DATA;
                end else if (hdr_twords != '0) begin
                    region_next = REGION_TRIG;
                end else begin
                    region_next = REGION_TAG;
                end
            end else begin
                unique case (region_reg)
                    REGION_DATA: begin
                        part_next       = part_take;
                        phase_next      = phase_take;
                        words_seen_next = seen_inc;
                        if (row_done) begin
                            res_valid        = 1'b1;
                            res.kind         = pagu_pkg::KIND_ROW;
                            res.sample_index = row_reg;
                            res.samples      = row_samples;
                            row_next         = row_reg + 1'b1;
                        end
                        if (seen_inc >= data_words_reg) begin
                            words_seen_next = '0;
                            phase_next      = PHASE_W0;
                            row_next        = '0;
                            region_next     = (trig_words_reg != '0) ? REGION_TRIG
                                                                     : REGION_TAG;
                        end
                    end
                    REGION_TRIG: begin
                        part_next       = part_take;
                        phase_next      = phase_take;
                        words_seen_next = seen_inc;
                        if (row_done) begin
                            res_valid        = 1'b1;
                            res.kind         = pagu_pkg::KIND_TRIG;
                            res.sample_index = {row_reg[7:0], 3'd0};
                            res.samples      = row_samples;
                            row_next         = row_reg + 1'b1;
                        end
                        if (seen_inc >= {3'd0, trig_words_reg}) begin
                            words_seen_next = '0;
                            phase_next      = PHASE_W0;
                            region_next     = REGION_TAG;
                        end
                    end
                    REGION_TAG: begin
                        res_valid   = 1'b1;
                        res.kind    = pagu_pkg::KIND_TAG;
                        res.extra   = in_word[29:0];
                        region_next = REGION_IDLE;
                    end
                    REGION_IDLE: begin
                        // Drop words outside a record
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg     <= REGION_IDLE;
            data_words_reg <= '0;
            trig_words_reg <= '0;
            words_seen_reg <= '0;
            phase_reg      <= PHASE_W0;
            row_reg        <= '0;
            part_reg       <= '0;
        end else begin
            region_reg     <= region_next;
            data_words_reg <= data_words_next;
            trig_words_reg <= trig_words_next;
            words_seen_reg <= words_seen_next;
            phase_reg      <= phase_next;
            row_reg        <= row_next;
            part_reg       <= part_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("triplet phase out of range");

    a_trig_has_words: assert property (@(posedge aclk) disable iff (!aresetn)
        region_reg == REGION_TRIG |-> trig_words_reg != '0)
        else $error("trigger region entered with no trigger words");

    a_row_on_third: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.kind == pagu_pkg::KIND_ROW || res.kind == pagu_pkg::KIND_TRIG))
        |-> (phase_reg == PHASE_W2 && !in_first))
        else $error("row emitted before its triplet was complete");

    a_header_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && in_first) |=> (phase_reg == PHASE_W0 && words_seen_reg == '0))
        else $error("header did not restart the unpacking");
`endif

endmodule

>>> hdl/pagu_out_stage.sv
// Result register of the packed ADC group unpacker: holds one result until
// the receiver takes it. Depends on pagu_pkg.
module pagu_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  pagu_pkg::result_t res,
    output logic              out_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output pagu_pkg::result_t m_res
);

    logic              valid_reg;
    pagu_pkg::result_t res_reg;

    // Reloadable when empty or when the held beat is taken this cycle
    assign out_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

>>> hdl/packed_adc_group_unpacker.sv
// Top level of the packed ADC group unpacker.
// Depends on pagu_pkg, pagu_in_stage, pagu_unpack and pagu_out_stage.
//
// Usage:
//   Slave channel: one 32-bit record word per beat on s_tdata; s_tuser
//   high marks the group header word and restarts the unpacking at once.
//   Master channel: at most one result beat per input beat. m_tuser gives
//   the kind (header start cell, channel row, trigger row, time tag);
//   m_tdata carries sample index, eight 12-bit samples and the 10-bit
//   start cell or 30-bit time tag. Fields that a kind does not use read as zero.
//   Data and trigger words that do not complete a triplet, words before
//   the first header and words after the time tag produce no beat.
// Timing:
//   An accepted word waits in the input register, is sliced combinationally by
//   the unpack logic and its result is captured in the result register.
//   One word per cycle is taken for as long as m_tready stays high; the
//   rate is set by the input register feeding the result register.
// Reset and stalls:
//   aresetn (synchronous, active low) empties both registers and returns
//   the block to waiting for a header. When the receiver stalls, the result
//   register holds its beat, the input register takes one more word if it is empty,
//   and s_tready is then low until the result beat is taken.
module packed_adc_group_unpacker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pagu_pkg::WORD_W-1:0]  s_tdata,  // [31:0] word
    input  logic                         s_tuser,  // [0] first (header word)
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [10:0] sample_index, [22:11] sample0, [34:23] sample1, [46:35] sample2,
    // [58:47] sample3, [70:59] sample4, [82:71] sample5, [94:83] sample6,
    // [106:95] sample7, [136:107] extra, [143:137] zero
    output logic [pagu_pkg::TDATA_W-1:0] m_tdata,
    output logic [pagu_pkg::KIND_W-1:0]  m_tuser   // [1:0] kind
);

    logic                        in_valid;
    logic [pagu_pkg::WORD_W-1:0] in_word;
    logic                        in_first;
    logic                        take;
    logic                        out_ready;
    logic                        res_valid;
    pagu_pkg::result_t           res;
    pagu_pkg::result_t           m_res;

    // Hold one accepted word
    pagu_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_word   (s_tdata),
        .s_first  (s_tuser),
        .take     (take),
        .in_valid (in_valid),
        .in_word  (in_word),
        .in_first (in_first)
    );

    // Advance the record state and slice the word
    pagu_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .in_first  (in_first),
        .out_ready (out_ready),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold the result beat for the receiver
    pagu_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    // Pack extra, samples and index from the top down, zero pad to bytes
    assign m_tdata = {7'd0, m_res.extra, m_res.samples, m_res.sample_index};
    assign m_tuser = m_res.kind;

endmodule
